FILE: hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stm_pkg.sv
package stm_pkg;

  localparam int unsigned BufRows = 27;
  localparam int unsigned VisRows = 20;
  localparam int unsigned TopBase = 19;
  localparam int unsigned RiseLimit = 11;
  localparam int unsigned CellRows = 8;
  localparam int unsigned CellCols = 6;
  localparam int unsigned CursorMax = 511;
  localparam int unsigned OutCols = 40;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PLACE = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_STILL = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    REG_DIR    = 2'd0,
    REG_COLUMN = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [4:0] row_index;
    logic [7:0] char_code;
    logic [1:0] operation;
  } in_beat_t;

  typedef struct packed {
    logic        char_accepted;
    logic [39:0] row_pixels;
  } out_beat_t;

  // per-cycle command to every row cell
  typedef struct packed {
    logic       clear;
    logic       shift_up;
    logic       shift_down;
    logic       shift_left;
    logic       shift_right;
    logic       write;
    logic [4:0] top;
    logic [8:0] cursor;
    logic [5:0] glyph;
    logic       blank;
  } cell_ctrl_t;

  function automatic logic [4:0] font_row(input logic [5:0] g, input logic [2:0] r);
    logic [34:0] f;
    begin
      case (g)
        6'd0:  f = {5'h11,5'h11,5'h1F,5'h11,5'h11,5'h0A,5'h04};
        6'd1:  f = {5'h0F,5'h11,5'h11,5'h0F,5'h11,5'h11,5'h0F};
        6'd2:  f = {5'h0E,5'h11,5'h01,5'h01,5'h01,5'h11,5'h0E};
        6'd3:  f = {5'h0F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0F};
        6'd4:  f = {5'h1F,5'h01,5'h01,5'h0F,5'h01,5'h01,5'h1F};
        6'd5:  f = {5'h01,5'h01,5'h01,5'h0F,5'h01,5'h01,5'h1F};
        6'd6:  f = {5'h0E,5'h11,5'h1D,5'h01,5'h01,5'h11,5'h0E};
        6'd7:  f = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
        6'd8:  f = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
        6'd9:  f = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h10,5'h10};
        6'd10: f = {5'h11,5'h09,5'h05,5'h03,5'h05,5'h09,5'h11};
        6'd11: f = {5'h1F,5'h01,5'h01,5'h01,5'h01,5'h01,5'h01};
        6'd12: f = {5'h11,5'h11,5'h11,5'h11,5'h15,5'h1B,5'h11};
        6'd13: f = {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11};
        6'd14: f = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
        6'd15: f = {5'h01,5'h01,5'h01,5'h0F,5'h11,5'h11,5'h0F};
        6'd16: f = {5'h16,5'h09,5'h15,5'h11,5'h11,5'h11,5'h0E};
        6'd17: f = {5'h11,5'h09,5'h05,5'h0F,5'h11,5'h11,5'h0F};
        6'd18: f = {5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E};
        6'd19: f = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
        6'd20: f = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h11};
        6'd21: f = {5'h04,5'h0A,5'h11,5'h11,5'h11,5'h11,5'h11};
        6'd22: f = {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11};
        6'd23: f = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
        6'd24: f = {5'h04,5'h04,5'h04,5'h04,5'h0A,5'h11,5'h11};
        6'd25: f = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
        6'd26: f = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
        6'd27: f = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h06,5'h04};
        6'd28: f = {5'h1F,5'h01,5'h02,5'h0C,5'h10,5'h11,5'h0E};
        6'd29: f = {5'h0E,5'h11,5'h10,5'h0C,5'h08,5'h10,5'h1F};
        6'd30: f = {5'h08,5'h08,5'h1F,5'h09,5'h0A,5'h0C,5'h08};
        6'd31: f = {5'h0E,5'h11,5'h10,5'h10,5'h0F,5'h01,5'h1F};
        6'd32: f = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h1C};
        6'd33: f = {5'h02,5'h02,5'h02,5'h04,5'h08,5'h10,5'h1F};
        6'd34: f = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
        6'd35: f = {5'h07,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
        default: f = '0;
      endcase
      if (r < 3'd7) font_row = f[r*5 +: 5];
      else font_row = '0;
    end
  endfunction

endpackage

FILE: hw/rtl/stm_row_cell.sv
module stm_row_cell #(
  parameter int unsigned Cols    = 256,
  parameter int unsigned VisCols = 40,
  parameter int unsigned RowIdx  = 0,
  parameter bit          Hshift  = 1'b1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stm_pkg::cell_ctrl_t ctrl_i,
  input  logic [Cols-1:0]     above_i,
  input  logic [Cols-1:0]     below_i,
  output logic [Cols-1:0]     row_o
);
  import stm_pkg::*;

  localparam int unsigned ColW = $clog2(Cols);

  logic [Cols-1:0] row_q, row_d;
  logic [4:0]      cell_r;
  logic [4:0]      bits;
  logic [5:0]      pat;

  assign cell_r = 5'(RowIdx) - ctrl_i.top;

  always_comb begin
    row_d = row_q;
    bits  = ctrl_i.blank ? 5'd0 : font_row(ctrl_i.glyph, cell_r[2:0]);
    pat   = {1'b0, bits};
    if (ctrl_i.clear) begin
      row_d = '0;
    end else if (ctrl_i.shift_up) begin
      row_d[VisCols-1:0] = below_i[VisCols-1:0];
    end else if (ctrl_i.shift_down) begin
      row_d[VisCols-1:0] = above_i[VisCols-1:0];
    end else if (Hshift && ctrl_i.shift_left) begin
      row_d[Cols-2:0] = row_q[Cols-1:1];
    end else if (Hshift && ctrl_i.shift_right) begin
      row_d[Cols-1:1] = row_q[Cols-2:0];
    end else if (ctrl_i.write && (5'(RowIdx) >= ctrl_i.top) && (cell_r < 5'(CellRows))) begin
      for (int c = 0; c < CellCols; c++) begin
        if (10'(ctrl_i.cursor) + 10'(c) < 10'(Cols)) begin
          row_d[ColW'(10'(ctrl_i.cursor) + 10'(c))] = pat[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

FILE: hw/rtl/scrolling_text_marquee_core.sv
// Text marquee over a 27-row frame held in a chain of row cells, each row
// exchanging its visible columns with its neighbours on vertical scrolls.
// Every command (start, place character, scroll tick, read row) is done by one
// update of all row cells, and its result beat is held in an output register;
// a new command is taken each cycle the output is free or being drained.
// Configuration writes go straight to the registers.
`include "assert_macros.svh"

module scrolling_text_marquee_core #(
  parameter int unsigned BufferCols  = 256,
  parameter int unsigned VisibleCols = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stm_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stm_pkg::out_beat_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i
);
  import stm_pkg::*;

  logic [2:0] dir_q;
  logic [5:0] anc_col_q;
  logic [4:0] anc_h_q;
  logic [8:0] cursor_q, cursor_d;
  logic [4:0] rise_q, rise_d;
  logic       out_valid_q;
  out_beat_t  out_q, out_d;
  cell_ctrl_t ctrl;
  logic       fire;
  logic [4:0] top;
  logic [7:0] code;
  logic       known;
  logic [9:0] cur_sum;
  logic [BufferCols-1:0] rows [BufRows];
  logic [BufferCols-1:0] rot_above [BufRows];
  logic [BufferCols-1:0] rot_below [BufRows];
  logic [VisibleCols-1:0] rd_row;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign top        = 5'(TopBase) - ((anc_h_q > 5'(TopBase)) ? 5'(TopBase) : anc_h_q);

  always_comb begin
    code = in_data_i.char_code;
    if (code inside {[8'h61:8'h7A]}) code = code - 8'd32;
    ctrl        = '0;
    ctrl.top    = top;
    ctrl.cursor = cursor_q;
    known       = 1'b1;
    if (code inside {[8'h41:8'h5A]}) begin
      ctrl.glyph = 6'(code - 8'h41);
    end else if (code inside {[8'h30:8'h39]}) begin
      ctrl.glyph = 6'(code - 8'h30) + 6'd26;
    end else if (code == 8'h20) begin
      ctrl.blank = 1'b1;
    end else begin
      known = 1'b0;
    end
    cursor_d = cursor_q;
    rise_d   = rise_q;
    cur_sum  = 10'(cursor_q) + 10'd7;
    out_d    = '0;
    rd_row   = '0;
    for (int r = 0; r < VisRows; r++) begin
      if (in_data_i.row_index == 5'(r)) rd_row = rows[r][VisibleCols-1:0];
    end
    if (fire) begin
      case (op_e'(in_data_i.operation))
        OP_START: begin
          ctrl.clear = 1'b1;
          cursor_d   = 9'(anc_col_q);
          rise_d     = top;
        end
        OP_PLACE: begin
          if (known) begin
            ctrl.write = 1'b1;
            cursor_d   = (cur_sum > 10'(CursorMax)) ? 9'(CursorMax) : cur_sum[8:0];
          end
          out_d.char_accepted = known;
        end
        OP_TICK: begin
          case (dir_e'(dir_q))
            DIR_UP: begin
              ctrl.shift_up = 1'b1;
              if (rise_q != 5'd0) rise_d = rise_q - 5'd1;
            end
            DIR_DOWN:  ctrl.shift_down  = 1'b1;
            DIR_LEFT:  ctrl.shift_left  = 1'b1;
            DIR_RIGHT: ctrl.shift_right = 1'b1;
            default: ;
          endcase
        end
        OP_READ: begin
          for (int c = 0; c < OutCols; c++) begin
            if (c < VisibleCols) out_d.row_pixels[c] = rd_row[c];
          end
        end
        default: ;
      endcase
    end
  end

  // neighbour wiring: up rotates visible rows once the countdown runs low
  always_comb begin
    for (int r = 0; r < BufRows; r++) begin
      rot_above[r] = rows[(r + BufRows - 1) % BufRows];
      if (r == BufRows - 1) begin
        rot_below[r] = rows[r];
      end else begin
        rot_below[r] = rows[r + 1];
      end
      if (rise_q < 5'(RiseLimit)) begin
        if (r == VisRows - 1) rot_below[r] = rows[0];
        else if (r >= VisRows) rot_below[r] = rows[r];
      end
    end
  end

  for (genvar g = 0; g < BufRows; g++) begin : g_cell
    stm_row_cell #(
      .Cols   (BufferCols),
      .VisCols(VisibleCols),
      .RowIdx (g),
      .Hshift (g < VisRows)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .above_i(rot_above[g]),
      .below_i(rot_below[g]),
      .row_o  (rows[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DIR_STILL;
      anc_col_q   <= '0;
      anc_h_q     <= '0;
      cursor_q    <= '0;
      rise_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DIR:    dir_q     <= cfg_data_i[2:0];
          REG_COLUMN: anc_col_q <= cfg_data_i;
          REG_HEIGHT: anc_h_q   <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      cursor_q <= cursor_d;
      rise_q   <= rise_d;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_fire_valid, clk_i, rst_ni, fire, out_valid_o, "beat lost")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o),
               "output beat changed while stalled")
  `ASSERT_IMPL(a_rise, clk_i, rst_ni, rise_q <= 5'(TopBase), "countdown out of range")

endmodule
